### rtl/c3rb_pkg.sv
// ============================================================================
// c3rb_pkg: shared types and constants of the 3x3 replicate-border convolution
// Holds the job record that passes from the front end to the back end.
// ============================================================================
package c3rb_pkg;

    localparam int REG_IDX_BITS = 3;
    localparam logic [REG_IDX_BITS-1:0] REG_WIDTH  = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_HEIGHT = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_KTOP   = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_KMID   = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_KBOT   = 3'd4;

    // Image geometry and data widths; the port and counter widths below
    // are sized for these values.
    localparam int MAX_WIDTH  = 1024;
    localparam int PIXEL_BITS = 16;
    localparam int COEF_BITS  = 16;

    localparam int CFG_BITS  = 48;
    localparam int SUM_BITS  = 35;
    localparam int ROW_BITS  = 16;
    localparam int COL_BITS  = 10;
    localparam int WREG_BITS = 11;

    // One window selection: which window rows feed kernel rows 0..2
    // (middle/bottom duplicated at the last row) and whether the right
    // column is replicated (last column).
    typedef struct packed {
        logic                 dup_row;
        logic                 dup_col;
        logic [ROW_BITS-1:0]  row;
        logic [COL_BITS-1:0]  col;
        logic                 last;
        logic                 done;
    } t_job;

endpackage

### rtl/c3rb_front.sv
// ============================================================================
// c3rb_front: line stores, window and position counters
// Accepts one pixel per transaction, updates the line memories and the 3x3
// window, and issues up to four result jobs with a window snapshot.
// ============================================================================
module c3rb_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [c3rb_pkg::WREG_BITS-1:0]      i_width,
    input  logic [c3rb_pkg::ROW_BITS-1:0]       i_height,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [PIXEL_BITS-1:0]        i_pixel,
    // job issue to the queue
    output logic                                o_job_valid,
    input  logic                                i_job_ready,
    output c3rb_pkg::t_job                      o_job,
    output logic signed [PIXEL_BITS-1:0]        o_win [9]
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = c3rb_pkg::COL_BITS;

    logic signed [PIXEL_BITS-1:0] r_upper [MAX_WIDTH];
    logic signed [PIXEL_BITS-1:0] r_middle [MAX_WIDTH];

    // Stage A: accepted pixel with its position, memory read in flight.
    logic                         r_a_valid;
    logic signed [PIXEL_BITS-1:0] r_a_pix;
    logic [CW-1:0]                r_a_col;
    logic [c3rb_pkg::ROW_BITS-1:0] r_a_row;
    logic                         r_a_lastc, r_a_lastr;
    logic signed [PIXEL_BITS-1:0] r_rd_t, r_rd_m;

    // Stage B: window updated, jobs being issued.
    logic                         r_b_valid;
    logic [3:0]                   r_b_pend;
    logic [CW-1:0]                r_b_col;
    logic [c3rb_pkg::ROW_BITS-1:0] r_b_row;
    logic signed [PIXEL_BITS-1:0] r_win [9];

    logic [CW-1:0]                 r_col;
    logic [c3rb_pkg::ROW_BITS-1:0] r_row;

    logic [c3rb_pkg::WREG_BITS-1:0] w_eff;
    logic [c3rb_pkg::ROW_BITS-1:0]  h_eff;
    logic [CW-1:0]                  col_use;
    logic                           lastc, lastr, acc, a_move, b_free;
    logic [3:0]                     n_pend, pick;
    logic [AW-1:0]                  rd_addr, a_addr;
    logic signed [PIXEL_BITS-1:0]   t_v, m_v;

    always_comb begin
        w_eff = i_width;
        if (i_width == '0) w_eff = c3rb_pkg::WREG_BITS'(1);
        else if (32'(i_width) > MAX_WIDTH) w_eff = c3rb_pkg::WREG_BITS'(MAX_WIDTH);
        h_eff = (i_height == '0) ? c3rb_pkg::ROW_BITS'(1) : i_height;
        col_use = (32'(r_col) >= MAX_WIDTH) ? CW'(MAX_WIDTH - 1) : r_col;
        lastc = ({1'b0, col_use} >= (w_eff - c3rb_pkg::WREG_BITS'(1)));
        lastr = (r_row >= (h_eff - c3rb_pkg::ROW_BITS'(1)));
    end

    // Pending job bits for the pixel leaving stage A:
    // 0: (r-1,c-1)  1: last row (r,c-1)  2: (r-1,c) at row end  3: last row (r,c)
    always_comb begin
        n_pend[0] = (r_a_col != '0) && (r_a_row != '0);
        n_pend[1] = (r_a_col != '0) && r_a_lastr;
        n_pend[2] = r_a_lastc && (r_a_row != '0);
        n_pend[3] = r_a_lastc && r_a_lastr;
    end

    logic job_fire;
    assign o_job_valid = r_b_valid && (r_b_pend != '0);
    assign job_fire    = o_job_valid && i_job_ready;
    assign pick        = r_b_pend & (~r_b_pend + 4'd1);

    logic [3:0] b_rest;
    assign b_rest = job_fire ? (r_b_pend & ~pick) : r_b_pend;
    assign b_free = !r_b_valid || (b_rest == '0);
    assign a_move = r_a_valid && b_free;
    assign o_ready = !r_a_valid || a_move;
    assign acc     = i_valid && o_ready;

    assign rd_addr = col_use[AW-1:0];
    assign a_addr  = r_a_col[AW-1:0];
    assign t_v = (r_a_row == '0) ? r_a_pix : r_rd_t;
    assign m_v = (r_a_row == '0) ? r_a_pix : r_rd_m;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd_t  <= (a_move && (a_addr == rd_addr)) ? m_v : r_upper[rd_addr];
            r_rd_m  <= (a_move && (a_addr == rd_addr)) ? r_a_pix : r_middle[rd_addr];
            r_a_pix <= i_pixel;
            r_a_col <= col_use;
            r_a_row <= r_row;
            r_a_lastc <= lastc;
            r_a_lastr <= lastr;
        end
        if (a_move) begin
            r_upper[a_addr]  <= m_v;
            r_middle[a_addr] <= r_a_pix;
        end
    end

    // A pixel at the same column right behind would read stale memory only
    // if width were one column; then the stage-A values are forwarded.
    // (With width one, every read follows the previous row's write at the
    // same address one transaction earlier.)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_b_pend  <= '0;
            r_col     <= '0;
            r_row     <= '0;
            for (int i = 0; i < 9; i++) r_win[i] <= '0;
        end else begin
            if (acc) begin
                if (lastc) begin
                    r_col <= '0;
                    r_row <= lastr ? '0 : r_row + c3rb_pkg::ROW_BITS'(1);
                end else begin
                    r_col <= col_use + CW'(1);
                end
            end
            if (acc) r_a_valid <= 1'b1;
            else if (a_move) r_a_valid <= 1'b0;
            if (a_move) begin
                r_b_valid <= 1'b1;
                r_b_pend  <= n_pend;
                r_b_col   <= r_a_col;
                r_b_row   <= r_a_row;
                if (r_a_col == '0) begin
                    for (int k = 0; k < 3; k++) begin
                        r_win[k]     <= t_v;
                        r_win[3 + k] <= m_v;
                        r_win[6 + k] <= r_a_pix;
                    end
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        r_win[3*k]     <= r_win[3*k + 1];
                        r_win[3*k + 1] <= r_win[3*k + 2];
                    end
                    r_win[2] <= t_v;
                    r_win[5] <= m_v;
                    r_win[8] <= r_a_pix;
                end
            end else if (job_fire) begin
                r_b_pend <= b_rest;
                if (b_rest == '0) r_b_valid <= 1'b0;
            end else if (r_b_valid && r_b_pend == '0) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_job = '0;
        o_job.dup_row = pick[1] || pick[3];
        o_job.dup_col = pick[2] || pick[3];
        o_job.row = (pick[0] || pick[2]) ? r_b_row - c3rb_pkg::ROW_BITS'(1) : r_b_row;
        o_job.col = (pick[0] || pick[1]) ? r_b_col - CW'(1) : r_b_col;
        o_job.last = ((r_b_pend & ~pick) == '0);
        o_job.done = pick[3];
    end

    for (genvar g = 0; g < 9; g++) begin : g_win
        assign o_win[g] = r_win[g];
    end
endmodule

### rtl/c3rb_queue.sv
// ============================================================================
// c3rb_queue: short job queue between front and back end
// Two-entry register queue carrying a job and its 3x3 window operands.
// ============================================================================
module c3rb_queue #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  c3rb_pkg::t_job                i_job,
    input  logic signed [PIXEL_BITS-1:0]  i_win [9],
    output logic                          o_valid,
    input  logic                          i_ready,
    output c3rb_pkg::t_job                o_job,
    output logic signed [PIXEL_BITS-1:0]  o_win [9]
);
    c3rb_pkg::t_job               r_job [2];
    logic signed [PIXEL_BITS-1:0] r_win [2][9];
    logic                         r_wp, r_rp;
    logic [1:0]                   r_cnt;
    logic                         push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;
    assign o_job = r_job[r_rp];
    for (genvar g = 0; g < 9; g++) begin : g_out
        assign o_win[g] = r_win[r_rp][g];
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_job[r_wp] <= i_job;
            for (int i = 0; i < 9; i++) r_win[r_wp][i] <= i_win[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

### rtl/c3rb_back.sv
// ============================================================================
// c3rb_back: multiply-accumulate pipeline
// Selects the window taps for a job, forms nine products in one stage and
// sums them in a registered tree, then holds the result in an output register.
// ============================================================================
module c3rb_back #(
    parameter int PIXEL_BITS = 16,
    parameter int COEF_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [c3rb_pkg::CFG_BITS-1:0]        i_kern [3],
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  c3rb_pkg::t_job                       i_job,
    input  logic signed [PIXEL_BITS-1:0]         i_win [9],
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [c3rb_pkg::SUM_BITS-1:0] o_filtered,
    output c3rb_pkg::t_job                       o_job
);
    localparam int PB = PIXEL_BITS + COEF_BITS;
    localparam int SB = c3rb_pkg::SUM_BITS;

    // Stages: 1 products, 2 partial sums, 3 output register.
    logic                 r_v1, r_v2, r_v3;
    c3rb_pkg::t_job       r_j1, r_j2, r_j3;
    logic signed [PB-1:0] r_prod [9];
    logic signed [SB-1:0] r_part [3];
    logic signed [SB-1:0] r_sum;
    logic                 adv3, adv2, adv1;
    logic signed [PIXEL_BITS-1:0] tap [9];
    logic signed [COEF_BITS-1:0]  cf  [9];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                int wr, wc;
                wr = (i_job.dup_row && k == 2) ? 2 : (i_job.dup_row ? k + 1 : k);
                wc = (i_job.dup_col && j == 2) ? 2 : (i_job.dup_col ? j + 1 : j);
                tap[3*k + j] = i_win[3*wr + wc];
                cf[3*k + j]  = i_kern[k][j*COEF_BITS +: COEF_BITS];
            end
        end
    end

    assign adv3 = !r_v3 || i_ready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign o_ready = adv1;

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_j1 <= i_job;
            for (int i = 0; i < 9; i++) r_prod[i] <= PB'(tap[i] * cf[i]);
        end
        if (adv2) begin
            r_j2 <= r_j1;
            for (int k = 0; k < 3; k++)
                r_part[k] <= SB'(r_prod[3*k]) + SB'(r_prod[3*k+1]) + SB'(r_prod[3*k+2]);
        end
        if (adv3) begin
            r_j3  <= r_j2;
            r_sum <= r_part[0] + r_part[1] + r_part[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    assign o_valid    = r_v3;
    assign o_filtered = r_sum;
    assign o_job      = r_j3;
endmodule

### rtl/conv3x3_replicate_border.sv
// Throughput: one pixel per cycle unless the job issue stage or the output holds
// it back; a pixel yields up to two results, and the pixel ending the last row yields
// four, issued one per cycle by the job issue stage while the queue has room.
// Reset (synchronous, active low) clears counters, window, queues and
// registers; line memories are not cleared and need no clearing pass.
// ============================================================================
// conv3x3_replicate_border: streaming 3x3 convolution, replicated borders
// Front end keeps line stores and window, back end multiplies and sums.
// ============================================================================
module conv3x3_replicate_border (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [c3rb_pkg::REG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [c3rb_pkg::CFG_BITS-1:0]        i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [15:0]                   i_pixel,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [34:0]                   o_filtered,
    output logic [15:0]                          o_out_row,
    output logic [9:0]                           o_out_col,
    output logic                                 o_last_of_run,
    output logic                                 o_frame_done
);
    localparam int MAX_WIDTH  = c3rb_pkg::MAX_WIDTH;
    localparam int PIXEL_BITS = c3rb_pkg::PIXEL_BITS;
    localparam int COEF_BITS  = c3rb_pkg::COEF_BITS;

    logic [c3rb_pkg::WREG_BITS-1:0] r_width;
    logic [c3rb_pkg::ROW_BITS-1:0]  r_height;
    logic [c3rb_pkg::CFG_BITS-1:0]  r_kern [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= c3rb_pkg::WREG_BITS'(1024);
            r_height <= c3rb_pkg::ROW_BITS'(1024);
            r_kern[0] <= '0;
            r_kern[1] <= c3rb_pkg::CFG_BITS'(65536);
            r_kern[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                c3rb_pkg::REG_WIDTH:  r_width  <= i_cfg_data[c3rb_pkg::WREG_BITS-1:0];
                c3rb_pkg::REG_HEIGHT: r_height <= i_cfg_data[c3rb_pkg::ROW_BITS-1:0];
                c3rb_pkg::REG_KTOP:   r_kern[0] <= i_cfg_data;
                c3rb_pkg::REG_KMID:   r_kern[1] <= i_cfg_data;
                c3rb_pkg::REG_KBOT:   r_kern[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [PIXEL_BITS-1:0] pix_ext;
    assign pix_ext = i_pixel[PIXEL_BITS-1:0];

    logic                         f_valid, f_ready, q_valid, q_ready;
    c3rb_pkg::t_job               f_job, q_job, b_job;
    logic signed [PIXEL_BITS-1:0] f_win [9];
    logic signed [PIXEL_BITS-1:0] q_win [9];

    c3rb_front #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_front (
        .i_clk, .i_rst_n,
        .i_width(r_width), .i_height(r_height),
        .i_valid, .o_ready, .i_pixel(pix_ext),
        .o_job_valid(f_valid), .i_job_ready(f_ready), .o_job(f_job), .o_win(f_win)
    );

    c3rb_queue #(.PIXEL_BITS(PIXEL_BITS)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_job(f_job), .i_win(f_win),
        .o_valid(q_valid), .i_ready(q_ready), .o_job(q_job), .o_win(q_win)
    );

    c3rb_back #(.PIXEL_BITS(PIXEL_BITS), .COEF_BITS(COEF_BITS)) u_back (
        .i_clk, .i_rst_n, .i_kern(r_kern),
        .i_valid(q_valid), .o_ready(q_ready), .i_job(q_job), .i_win(q_win),
        .o_valid, .i_ready, .o_filtered, .o_job(b_job)
    );

    assign o_out_row     = b_job.row;
    assign o_out_col     = b_job.col;
    assign o_last_of_run = b_job.last;
    assign o_frame_done  = b_job.done;
endmodule
